// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the level meter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/brlm_pkg.sv =====
// ----------------------------------------------------------------------------
// brlm_pkg
// widths, constants, codes and shared types of the block rms level meter
// ----------------------------------------------------------------------------
`default_nettype none

package brlm_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned LEVEL_W   = 16;
	localparam int unsigned POS_W     = 8;
	localparam int unsigned CFG_W     = 13;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned BLEN_W    = 13;
	localparam int unsigned BPG_W     = 5;
	localparam int unsigned GPF_W     = 5;
	localparam int unsigned CNT_W     = 12;
	localparam int unsigned SQ_W      = 2 * SAMPLE_W;
	localparam int unsigned BSUM_W    = 42;
	localparam int unsigned GSUM_W    = 46;
	localparam int unsigned BIG_W     = 4;
	localparam int unsigned GIF_W     = 4;
	localparam int unsigned DIVISOR_W = 17;
	localparam int unsigned ROOT_W    = GSUM_W / 2;
	localparam int unsigned REM_W     = ROOT_W + 3;
	localparam int unsigned STEP_W    = 6;
	localparam int unsigned DIV_STEPS  = GSUM_W;
	localparam int unsigned ROOT_STEPS = ROOT_W;

	localparam logic [BLEN_W-1:0] MAX_BLOCK_LEN    = 13'd4096;
	localparam logic [BPG_W-1:0]  MAX_GROUP_BLOCKS = 5'd16;
	localparam logic [GPF_W-1:0]  MAX_FRAME_GROUPS = 5'd16;

	localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd200;
	localparam logic [BPG_W-1:0]  BPG_RESET  = 5'd10;
	localparam logic [GPF_W-1:0]  GPF_RESET  = 5'd8;

	localparam logic [BSUM_W-1:0]  BSUM_MAX   = {BSUM_W{1'b1}};
	localparam logic [GSUM_W-1:0]  GSUM_MAX   = {GSUM_W{1'b1}};
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = {LEVEL_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_LEN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCKS_PER_GROUP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GROUPS_PER_FRAME = 2'd2;

	typedef enum logic [1:0] {
		KIND_BLOCK = 2'd0,
		KIND_GROUP = 2'd1,
		KIND_MIN   = 2'd2,
		KIND_MAX   = 2'd3
	} brlm_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_BLK_START,
		ST_BLK_WAIT,
		ST_BLK_EMIT,
		ST_GRP_START,
		ST_GRP_WAIT,
		ST_GRP_EMIT,
		ST_MIN_EMIT,
		ST_MAX_EMIT
	} brlm_state_t;

	typedef enum logic [1:0] {
		DR_IDLE,
		DR_DIV,
		DR_ROOT
	} brlm_dr_state_t;

	typedef struct packed {
		logic                 start;
		logic [GSUM_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
	} brlm_dr_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [LEVEL_W-1:0] level;
	} brlm_dr_resp_t;

	function automatic logic [BLEN_W-1:0] clamp_blen(input logic [BLEN_W-1:0] v);
		logic [BLEN_W-1:0] r;
		if (v == '0) r = BLEN_W'(1);
		else if (v > MAX_BLOCK_LEN) r = MAX_BLOCK_LEN;
		else r = v;
		return r;
	endfunction

	function automatic logic [BPG_W-1:0] clamp_count(input logic [BPG_W-1:0] v,
			input logic [BPG_W-1:0] hi);
		logic [BPG_W-1:0] r;
		if (v == '0) r = BPG_W'(1);
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brlm_if.sv =====
// ----------------------------------------------------------------------------
// brlm channel interfaces
// valid/ready channels for input samples and for level results
// ----------------------------------------------------------------------------
`default_nettype none

interface brlm_sample_if import brlm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface brlm_result_if import brlm_pkg::*; ();
	logic               valid;
	logic               ready;
	brlm_kind_t         result_kind;
	logic [LEVEL_W-1:0] level;
	logic [POS_W-1:0]   position;
	logic               last;

	modport source(output valid, output result_kind, output level, output position,
		output last, input ready);
	modport sink(input valid, input result_kind, input level, input position,
		input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brlm_divroot.sv =====
// ----------------------------------------------------------------------------
// brlm_divroot
// shared compare-subtract unit: restoring divide, then floor square root
// ----------------------------------------------------------------------------
`default_nettype none

module brlm_divroot import brlm_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire brlm_dr_req_t  req,
	output      brlm_dr_resp_t resp
);

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

	brlm_dr_state_t state_q, state_d;
	logic [STEP_W-1:0]    cnt_q;
	logic [GSUM_W-1:0]    work_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic                 done_q;

	logic [REM_W-1:0] op_a, op_b, rem_next;
	logic [REM_W:0]   diff;
	logic             ge;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DR_IDLE: if (req.start) state_d = DR_DIV;
			DR_DIV:  if (cnt_q == '0) state_d = DR_ROOT;
			DR_ROOT: if (cnt_q == '0) state_d = DR_IDLE;
			default: state_d = DR_IDLE;
		endcase
	end

	// operand select for the single subtractor
	always_comb begin
		unique case (state_q)
			DR_ROOT: begin
				op_a = {rem_q[REM_W-3:0], work_q[GSUM_W-1 -: 2]};
				op_b = {1'b0, root_q, 2'b01};
			end
			default: begin
				op_a = {{(REM_W-DIVISOR_W-1){1'b0}}, rem_q[DIVISOR_W-1:0], work_q[GSUM_W-1]};
				op_b = {{(REM_W-DIVISOR_W){1'b0}}, divisor_q};
			end
		endcase
		diff     = {1'b0, op_a} - {1'b0, op_b};
		ge       = ~diff[REM_W];
		rem_next = ge ? diff[REM_W-1:0] : op_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DR_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DR_ROOT) && (cnt_q == '0);
			unique case (state_q)
				DR_IDLE: cnt_q <= DIV_LAST;
				DR_DIV:  cnt_q <= (cnt_q == '0) ? ROOT_LAST : cnt_q - STEP_W'(1);
				DR_ROOT: cnt_q <= cnt_q - STEP_W'(1);
				default: cnt_q <= '0;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			DR_IDLE: begin
				work_q    <= req.dividend;
				divisor_q <= req.divisor;
				rem_q     <= '0;
				root_q    <= '0;
			end
			DR_DIV: begin
				// quotient bits shift in behind the dividend
				work_q <= {work_q[GSUM_W-2:0], ge};
				rem_q  <= (cnt_q == '0) ? '0 : rem_next;
				root_q <= '0;
			end
			DR_ROOT: begin
				work_q <= {work_q[GSUM_W-3:0], 2'b00};
				rem_q  <= rem_next;
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	always_comb begin
		resp.busy  = (state_q != DR_IDLE);
		resp.done  = done_q;
		resp.level = (|root_q[ROOT_W-1:LEVEL_W]) ? LEVEL_FULL : root_q[LEVEL_W-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/core/block_rms_level_meter_core.sv =====
// ----------------------------------------------------------------------------
// block_rms_level_meter_core
// block and group rms level meter with frame min/max, over signed 16-bit audio samples
// ----------------------------------------------------------------------------
// usage:
//  - samples: sink channel, one signed pcm sample per beat
//  - results: source channel, beats of (result_kind, level, position, last);
//    a sample yields none, one block beat, block+group beats, or at frame end
//    block, group, minimum and maximum beats; last marks the final one
//  - cfg_we/cfg_index/cfg_data: register writes, only while the block is idle
//  - a sample that closes no block passes the square and accumulate states
//  - a block end adds one pass of the shared divide/root unit: 46 divide
//    steps plus 23 root steps before the block beat; a group end adds a
//    second pass
//  - samples is ready only while no sample is in work; a finished beat waits
//    in the output register, so a stalled receiver holds the next result
//    and, through it, the next sample that needs an output slot
//  - reset clears all sums, counts and min/max and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module block_rms_level_meter_core import brlm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	brlm_sample_if.sink               samples,
	brlm_result_if.source             results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration registers, raw as written
	logic [BLEN_W-1:0] blen_q;
	logic [BPG_W-1:0]  bpg_q;
	logic [GPF_W-1:0]  gpf_q;
	logic [BLEN_W-1:0] blen_eff;
	logic [BPG_W-1:0]  bpg_eff;
	logic [GPF_W-1:0]  gpf_eff;

	brlm_state_t state_q, state_d;

	// running meter state
	logic [CNT_W-1:0]   sample_count_q;
	logic [BSUM_W-1:0]  block_sum_q;
	logic [GSUM_W-1:0]  group_sum_q;
	logic [BIG_W-1:0]   big_q;
	logic [GIF_W-1:0]   gif_q;
	logic [LEVEL_W-1:0] min_q;
	logic [LEVEL_W-1:0] max_q;

	// working registers
	logic [SAMPLE_W-1:0] sample_q;
	logic [SQ_W-1:0]     sq_q;
	logic [BLEN_W-1:0]   div_cnt_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic [POS_W-1:0]    pos_q;

	// output register
	logic               out_valid_q;
	brlm_kind_t         out_kind_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_last_q;

	brlm_dr_req_t  dr_req;
	brlm_dr_resp_t dr_resp;

	// combinational helpers
	logic [SAMPLE_W-1:0]     mag;
	logic [SQ_W-1:0]         sq_next;
	logic [BLEN_W-1:0]       count;
	logic                    block_open;
	logic [BSUM_W:0]         bs_wide;
	logic [BSUM_W-1:0]       bs_sat;
	logic [GSUM_W:0]         gs_wide;
	logic [GSUM_W-1:0]       gs_sat;
	logic [BLEN_W+BPG_W-1:0] grp_prod;
	logic [GIF_W+BPG_W-1:0]  pos_sum;
	logic [BPG_W-1:0]        big_next;
	logic [GPF_W-1:0]        gif_next;
	logic                    group_open;
	logic                    frame_open;
	logic                    slot_free;

	// outputs of the sequencer
	logic               emit;
	brlm_kind_t         emit_kind;
	logic [LEVEL_W-1:0] emit_level;
	logic [POS_W-1:0]   emit_pos;
	logic               emit_last;
	logic               in_ready;

	assign blen_eff = clamp_blen(blen_q);
	assign bpg_eff  = clamp_count(bpg_q, MAX_GROUP_BLOCKS);
	assign gpf_eff  = clamp_count(gpf_q, MAX_FRAME_GROUPS);

	always_comb begin
		// magnitude of the most negative sample is 0x8000, still exact unsigned
		mag        = sample_q[SAMPLE_W-1] ? (SAMPLE_W'(0) - sample_q) : sample_q;
		sq_next    = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};
		count      = {1'b0, sample_count_q} + BLEN_W'(1);
		block_open = (count < blen_eff);
		bs_wide    = {1'b0, block_sum_q} + {{(BSUM_W+1-SQ_W){1'b0}}, sq_q};
		bs_sat     = bs_wide[BSUM_W] ? BSUM_MAX : bs_wide[BSUM_W-1:0];
		gs_wide    = {1'b0, group_sum_q} + {{(GSUM_W+1-BSUM_W){1'b0}}, block_sum_q};
		gs_sat     = gs_wide[GSUM_W] ? GSUM_MAX : gs_wide[GSUM_W-1:0];
		grp_prod   = {{BPG_W{1'b0}}, blen_eff} * {{BLEN_W{1'b0}}, bpg_eff};
		// block position in frame: group index times blocks per group plus block
		pos_sum    = {{BPG_W{1'b0}}, gif_q} * {{GIF_W{1'b0}}, bpg_eff}
			+ {{BPG_W{1'b0}}, big_q};
		big_next   = {1'b0, big_q} + BPG_W'(1);
		gif_next   = {1'b0, gif_q} + GPF_W'(1);
		group_open = (big_next < bpg_eff);
		frame_open = (gif_next < gpf_eff);
		slot_free  = !out_valid_q || results.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (samples.valid) state_d = ST_SQUARE;
			ST_SQUARE:    state_d = ST_ACCUM;
			ST_ACCUM:     state_d = block_open ? ST_IDLE : ST_BLK_START;
			ST_BLK_START: state_d = ST_BLK_WAIT;
			ST_BLK_WAIT:  if (dr_resp.done) state_d = ST_BLK_EMIT;
			ST_BLK_EMIT:  if (slot_free) state_d = group_open ? ST_IDLE : ST_GRP_START;
			ST_GRP_START: state_d = ST_GRP_WAIT;
			ST_GRP_WAIT:  if (dr_resp.done) state_d = ST_GRP_EMIT;
			ST_GRP_EMIT:  if (slot_free) state_d = frame_open ? ST_IDLE : ST_MIN_EMIT;
			ST_MIN_EMIT:  if (slot_free) state_d = ST_MAX_EMIT;
			ST_MAX_EMIT:  if (slot_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready        = 1'b0;
		emit            = 1'b0;
		emit_kind       = KIND_BLOCK;
		emit_level      = lvl_q;
		emit_pos        = pos_q;
		emit_last       = 1'b0;
		dr_req.start    = 1'b0;
		dr_req.dividend = {{(GSUM_W-BSUM_W){1'b0}}, block_sum_q};
		dr_req.divisor  = {{(DIVISOR_W-BLEN_W){1'b0}}, div_cnt_q};
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_BLK_START: dr_req.start = 1'b1;
			ST_BLK_EMIT: begin
				emit      = slot_free;
				emit_last = group_open;
			end
			ST_GRP_START: begin
				// group mean divides by block_len times blocks_per_group
				dr_req.start    = 1'b1;
				dr_req.dividend = group_sum_q;
				dr_req.divisor  = grp_prod[DIVISOR_W-1:0];
			end
			ST_GRP_EMIT: begin
				emit      = slot_free;
				emit_kind = KIND_GROUP;
				emit_pos  = {{(POS_W-GIF_W){1'b0}}, gif_q};
				emit_last = frame_open;
			end
			ST_MIN_EMIT: begin
				emit       = slot_free;
				emit_kind  = KIND_MIN;
				emit_level = min_q;
				emit_pos   = '0;
			end
			ST_MAX_EMIT: begin
				emit       = slot_free;
				emit_kind  = KIND_MAX;
				emit_level = max_q;
				emit_pos   = '0;
				emit_last  = 1'b1;
			end
			default: ;
		endcase
	end

	assign samples.ready = in_ready;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= BLEN_RESET;
			bpg_q  <= BPG_RESET;
			gpf_q  <= GPF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_BLOCK_LEN:        blen_q <= cfg_data[BLEN_W-1:0];
				CFG_IDX_BLOCKS_PER_GROUP: bpg_q  <= cfg_data[BPG_W-1:0];
				CFG_IDX_GROUPS_PER_FRAME: gpf_q  <= cfg_data[GPF_W-1:0];
				default: ;
			endcase
		end
	end

	// meter state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= '0;
			block_sum_q    <= '0;
			group_sum_q    <= '0;
			big_q          <= '0;
			gif_q          <= '0;
			min_q          <= LEVEL_FULL;
			max_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_ACCUM: begin
					block_sum_q <= bs_sat;
					if (block_open) sample_count_q <= count[CNT_W-1:0];
				end
				ST_BLK_START: begin
					// divider latches the block sum on this edge
					group_sum_q    <= gs_sat;
					block_sum_q    <= '0;
					sample_count_q <= '0;
				end
				ST_BLK_WAIT: begin
					if (dr_resp.done) begin
						if (dr_resp.level < min_q) min_q <= dr_resp.level;
						if (dr_resp.level > max_q) max_q <= dr_resp.level;
					end
				end
				ST_BLK_EMIT: begin
					if (slot_free) big_q <= group_open ? big_next[BIG_W-1:0] : '0;
				end
				ST_GRP_START: group_sum_q <= '0;
				ST_GRP_EMIT: begin
					if (slot_free) gif_q <= frame_open ? gif_next[GIF_W-1:0] : '0;
				end
				ST_MAX_EMIT: begin
					if (slot_free) begin
						min_q <= LEVEL_FULL;
						max_q <= '0;
					end
				end
				default: ;
			endcase
			if (emit) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (samples.valid && in_ready) sample_q <= samples.sample;
		if (state_q == ST_SQUARE) sq_q <= sq_next;
		if (state_q == ST_ACCUM) div_cnt_q <= count;
		if (state_q == ST_BLK_START) pos_q <= pos_sum[POS_W-1:0];
		if (dr_resp.done) lvl_q <= dr_resp.level;
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_level_q <= emit_level;
			out_pos_q   <= emit_pos;
			out_last_q  <= emit_last;
		end
	end

	brlm_divroot u_divroot (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dr_req),
		.resp   (dr_resp)
	);

	assign results.valid       = out_valid_q;
	assign results.result_kind = out_kind_q;
	assign results.level       = out_level_q;
	assign results.position    = out_pos_q;
	assign results.last        = out_last_q;

	// no sample is taken while the shared unit is still working
	`ASSERT_IMPLIES(a_ready_unit_idle, clk, arst_n, in_ready, !dr_resp.busy, "ready while busy")
	// a new divide never lands on a unit in flight
	`ASSERT_IMPLIES(a_start_idle, clk, arst_n, dr_req.start, !dr_resp.busy, "start while busy")
	// a finished root is always awaited by the sequencer
	`ASSERT_IMPLIES(a_done_waited, clk, arst_n, dr_resp.done,
		(state_q == ST_BLK_WAIT) || (state_q == ST_GRP_WAIT), "done unawaited")
	// an accepted start keeps the unit busy on the next cycle
	`ASSERT_NEXT(a_start_busy, clk, arst_n, dr_req.start, dr_resp.busy, "unit not busy")

endmodule

`default_nettype wire
